@@ rtl/core/crc8_framed_packet_receiver_defines.svh @@
// Assertion macros for the CRC-8 framed packet receiver RTL.
// Each macro expects clk and arst_n in scope.
`ifndef CRC8_FRAMED_PACKET_RECEIVER_DEFINES_SVH
`define CRC8_FRAMED_PACKET_RECEIVER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define CRC8FPR_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset.
`define CRC8FPR_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/core/crc8fpr_pkg.sv @@
// Package for the CRC-8 framed packet receiver: codes, types, CRC step.
// No dependencies.
`default_nettype none

package crc8fpr_pkg;

	localparam int BUFFER_BYTES_DEF = 64;
	localparam int STORE_MAX        = 60;
	localparam int QUEUE_DEPTH      = 2;

	localparam logic [7:0] CRC_POLY = 8'h07;
	localparam logic [7:0] HDR_A    = 8'hAA;
	localparam logic [7:0] HDR_B    = 8'h55;
	localparam logic [7:0] TAIL_A   = 8'h0D;
	localparam logic [7:0] TAIL_B   = 8'h0A;

	typedef enum logic [1:0] {
		ST_OK  = 2'd0,
		ST_CRC = 2'd1,
		ST_LEN = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		PH_HDR1, PH_HDR2, PH_LEN, PH_CMD, PH_DATA, PH_CRC, PH_TAIL1, PH_TAIL2
	} phase_t;

	typedef enum logic [1:0] {
		B_IDLE, B_READ, B_PUSH
	} back_st_t;

	typedef struct packed {
		status_t    status;
		logic [7:0] command;
		logic [5:0] length;
	} job_t;

	typedef struct packed {
		logic       en;
		logic [5:0] addr;
		logic [7:0] data;
	} mem_wr_t;

	function automatic int len_limit(input int buffer_bytes);
		int lim;
		begin
			lim = (buffer_bytes > 4) ? buffer_bytes - 4 : 0;
			return (lim > STORE_MAX) ? STORE_MAX : lim;
		end
	endfunction

	function automatic logic [7:0] crc_step(input logic [7:0] c, input logic [7:0] b);
		logic [7:0] v;
		begin
			v = c ^ b;
			for (int i = 0; i < 8; i++) begin
				v = v[7] ? ((v << 1) ^ CRC_POLY) : (v << 1);
			end
			return v;
		end
	endfunction

endpackage

`default_nettype wire

@@ rtl/core/crc8fpr_if.sv @@
// Valid/ready channel interfaces: received bytes in, frame results out.
// No dependencies.
`default_nettype none

interface crc8fpr_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_byte, output ready);
endinterface

interface crc8fpr_result_if;
	logic       valid;
	logic       ready;
	logic [1:0] status;
	logic [7:0] command;
	logic [5:0] payload_length;
	logic       has_byte;
	logic [7:0] data_byte;
	logic [5:0] byte_index;
	logic       last;

	modport source (output valid, output status, output command, output payload_length,
		output has_byte, output data_byte, output byte_index, output last, input ready);
	modport sink   (input valid, input status, input command, input payload_length,
		input has_byte, input data_byte, input byte_index, input last, output ready);
endinterface

`default_nettype wire

@@ rtl/core/crc8_framed_packet_receiver.sv @@
// CRC-8 framed packet receiver.
// Bytes enter on rx (valid/ready). Frames are AA 55, length, command,
// payload, CRC-8 (poly 07, init 0, over length/command/payload), 0D 0A.
// Results leave on result (valid/ready): one per payload byte, or one for
// an empty payload, with the last one flagged; a CRC mismatch or an
// oversize length gives a single error result. Bad header/tail bytes are
// dropped silently.
// The parser takes one byte per cycle while rx.ready is high. Each
// payload result takes a registered store read, then an output load. A
// frame's job enters the job queue when its final 0A byte is accepted.
// rx.ready drops in the payload phase while an earlier job is queued or
// draining, since the payload store has one write and one read port; it
// also drops when the two-entry job queue is full.
// A stalled result receiver holds the output register; the parser keeps
// taking bytes until the job queue or the store blocks it.
// Reset clears parser, queue and sequencer; the store is not cleared.
// Depends on crc8fpr_pkg, crc8fpr_if, crc8fpr_front, crc8fpr_queue, crc8fpr_back.
`default_nettype none

module crc8_framed_packet_receiver #(
	parameter int BUFFER_BYTES = crc8fpr_pkg::BUFFER_BYTES_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	crc8fpr_byte_if.sink       rx,
	crc8fpr_result_if.source   result
);

	crc8fpr_pkg::job_t    push_job, head;
	crc8fpr_pkg::mem_wr_t wr;
	logic push, pop, q_empty, q_full, active, back_busy;

	assign back_busy = !q_empty || active;

	crc8fpr_front #(.BUFFER_BYTES(BUFFER_BYTES)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.rx        (rx),
		.q_full    (q_full),
		.back_busy (back_busy),
		.push      (push),
		.push_job  (push_job),
		.wr        (wr)
	);

	crc8fpr_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.head     (head),
		.empty    (q_empty),
		.full     (q_full)
	);

	crc8fpr_back #(.BUFFER_BYTES(BUFFER_BYTES)) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (wr),
		.head    (head),
		.q_empty (q_empty),
		.pop     (pop),
		.active  (active),
		.result  (result)
	);

endmodule

`default_nettype wire

@@ rtl/core/crc8fpr_front.sv @@
// Frame parser: accepts bytes, tracks CRC, writes payload, queues result jobs.
// Depends on crc8fpr_pkg and crc8fpr_byte_if.
`default_nettype none

module crc8fpr_front #(
	parameter int BUFFER_BYTES = crc8fpr_pkg::BUFFER_BYTES_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	crc8fpr_byte_if.sink               rx,
	input  wire logic                  q_full,
	input  wire logic                  back_busy,
	output logic                       push,
	output crc8fpr_pkg::job_t          push_job,
	output crc8fpr_pkg::mem_wr_t       wr
);

	localparam int LenLimit = crc8fpr_pkg::len_limit(BUFFER_BYTES);

	crc8fpr_pkg::phase_t phase_q, phase_nx;
	logic [5:0] cnt_q, len_q;
	logic [7:0] cmd_q, crc_q;
	logic [7:0] b, crc_nx;
	logic [5:0] cnt_inc;
	logic       accept, len_ok;

	assign b        = rx.rx_byte;
	assign rx.ready = !q_full && !(phase_q == crc8fpr_pkg::PH_DATA && back_busy);
	assign accept   = rx.valid && rx.ready;
	assign len_ok   = (b <= 8'(LenLimit));
	assign cnt_inc  = cnt_q + 6'd1;
	assign crc_nx   = crc8fpr_pkg::crc_step((phase_q == crc8fpr_pkg::PH_LEN) ? 8'h00 : crc_q, b);

	always_comb begin
		phase_nx = phase_q;
		case (phase_q)
			crc8fpr_pkg::PH_HDR1: if (b == crc8fpr_pkg::HDR_A) phase_nx = crc8fpr_pkg::PH_HDR2;
			crc8fpr_pkg::PH_HDR2: begin
				phase_nx = (b == crc8fpr_pkg::HDR_B) ? crc8fpr_pkg::PH_LEN : crc8fpr_pkg::PH_HDR1;
			end
			crc8fpr_pkg::PH_LEN: begin
				phase_nx = len_ok ? crc8fpr_pkg::PH_CMD : crc8fpr_pkg::PH_HDR1;
			end
			crc8fpr_pkg::PH_CMD: begin
				phase_nx = (len_q != 6'd0) ? crc8fpr_pkg::PH_DATA : crc8fpr_pkg::PH_CRC;
			end
			crc8fpr_pkg::PH_DATA: if (cnt_inc >= len_q) phase_nx = crc8fpr_pkg::PH_CRC;
			crc8fpr_pkg::PH_CRC: begin
				phase_nx = (b == crc_q) ? crc8fpr_pkg::PH_TAIL1 : crc8fpr_pkg::PH_HDR1;
			end
			crc8fpr_pkg::PH_TAIL1: begin
				phase_nx = (b == crc8fpr_pkg::TAIL_A) ? crc8fpr_pkg::PH_TAIL2 : crc8fpr_pkg::PH_HDR1;
			end
			default: phase_nx = crc8fpr_pkg::PH_HDR1;
		endcase
	end

	always_comb begin
		push             = 1'b0;
		push_job.status  = crc8fpr_pkg::ST_OK;
		push_job.command = 8'h00;
		push_job.length  = 6'd0;
		wr.en            = 1'b0;
		wr.addr          = cnt_q;
		wr.data          = b;
		case (phase_q)
			crc8fpr_pkg::PH_LEN: begin
				push            = accept && !len_ok;
				push_job.status = crc8fpr_pkg::ST_LEN;
			end
			crc8fpr_pkg::PH_DATA: wr.en = accept;
			crc8fpr_pkg::PH_CRC: begin
				push            = accept && (b != crc_q);
				push_job.status = crc8fpr_pkg::ST_CRC;
			end
			crc8fpr_pkg::PH_TAIL2: begin
				push             = accept && (b == crc8fpr_pkg::TAIL_B);
				push_job.command = cmd_q;
				push_job.length  = len_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= crc8fpr_pkg::PH_HDR1;
			cnt_q   <= 6'd0;
			len_q   <= 6'd0;
			cmd_q   <= 8'h00;
			crc_q   <= 8'h00;
		end else if (accept) begin
			phase_q <= phase_nx;
			case (phase_q)
				crc8fpr_pkg::PH_LEN: begin
					crc_q <= crc_nx;
					if (len_ok) begin
						len_q <= b[5:0];
						cnt_q <= 6'd0;
					end
				end
				crc8fpr_pkg::PH_CMD: begin
					cmd_q <= b;
					crc_q <= crc_nx;
				end
				crc8fpr_pkg::PH_DATA: begin
					cnt_q <= cnt_inc;
					crc_q <= crc_nx;
				end
				default: ;
			endcase
		end
	end

endmodule

`default_nettype wire

@@ rtl/core/crc8fpr_queue.sv @@
// Short job FIFO between the parser and the result sequencer.
// Depends on crc8fpr_pkg.
`default_nettype none

module crc8fpr_queue (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	input  wire crc8fpr_pkg::job_t  push_job,
	input  wire logic               pop,
	output crc8fpr_pkg::job_t       head,
	output logic                    empty,
	output logic                    full
);

	localparam int Depth = crc8fpr_pkg::QUEUE_DEPTH;
	localparam int PW    = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CW    = $clog2(Depth + 1);

	crc8fpr_pkg::job_t ent_q [Depth];
	logic [PW-1:0] wp_q, rp_q;
	logic [CW-1:0] cnt_q;
	logic          do_push, do_pop;

	assign empty   = (cnt_q == CW'(0));
	assign full    = (cnt_q == CW'(Depth));
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign head    = ent_q[rp_q];

	always_ff @(posedge clk) begin
		if (do_push) ent_q[wp_q] <= push_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) wp_q <= (wp_q == PW'(Depth - 1)) ? '0 : wp_q + PW'(1);
			if (do_pop)  rp_q <= (rp_q == PW'(Depth - 1)) ? '0 : rp_q + PW'(1);
			if (do_push && !do_pop)      cnt_q <= cnt_q + CW'(1);
			else if (do_pop && !do_push) cnt_q <= cnt_q - CW'(1);
		end
	end

endmodule

`default_nettype wire

@@ rtl/core/crc8fpr_back.sv @@
// Result sequencer: payload store, job execution, registered result output.
// Depends on crc8fpr_pkg, crc8fpr_result_if and the assertion macro header.
`default_nettype none
`include "crc8_framed_packet_receiver_defines.svh"

module crc8fpr_back #(
	parameter int BUFFER_BYTES = crc8fpr_pkg::BUFFER_BYTES_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire crc8fpr_pkg::mem_wr_t  wr,
	input  wire crc8fpr_pkg::job_t     head,
	input  wire logic                  q_empty,
	output logic                       pop,
	output logic                       active,
	crc8fpr_result_if.source           result
);

	localparam int Depth = (crc8fpr_pkg::len_limit(BUFFER_BYTES) > 0) ?
		crc8fpr_pkg::len_limit(BUFFER_BYTES) : 1;
	localparam int AW    = (Depth > 1) ? $clog2(Depth) : 1;

	logic [7:0] mem [Depth];
	logic [7:0] rd_data_q;

	crc8fpr_pkg::back_st_t st_q, st_nx;
	crc8fpr_pkg::job_t     job_q;
	logic [5:0] idx_q;
	logic       oval_q, out_free, load, has, lst;

	always_ff @(posedge clk) begin
		if (wr.en) mem[wr.addr[AW-1:0]] <= wr.data;
		rd_data_q <= mem[idx_q[AW-1:0]];
	end

	assign out_free = !oval_q || result.ready;
	assign has      = (job_q.status == crc8fpr_pkg::ST_OK) && (job_q.length != 6'd0);
	assign lst      = !has || ((idx_q + 6'd1) == job_q.length);

	always_comb begin
		st_nx = st_q;
		case (st_q)
			crc8fpr_pkg::B_IDLE: if (!q_empty) st_nx = crc8fpr_pkg::B_READ;
			crc8fpr_pkg::B_READ: st_nx = crc8fpr_pkg::B_PUSH;
			crc8fpr_pkg::B_PUSH: begin
				if (out_free) st_nx = lst ? crc8fpr_pkg::B_IDLE : crc8fpr_pkg::B_READ;
			end
			default: st_nx = crc8fpr_pkg::B_IDLE;
		endcase
	end

	always_comb begin
		pop    = 1'b0;
		load   = 1'b0;
		active = 1'b1;
		case (st_q)
			crc8fpr_pkg::B_IDLE: begin
				pop    = !q_empty;
				active = 1'b0;
			end
			crc8fpr_pkg::B_PUSH: load = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= crc8fpr_pkg::B_IDLE;
			idx_q  <= 6'd0;
			oval_q <= 1'b0;
		end else begin
			st_q <= st_nx;
			if (pop) idx_q <= 6'd0;
			else if (load && !lst) idx_q <= idx_q + 6'd1;
			if (load) oval_q <= 1'b1;
			else if (result.ready) oval_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) job_q <= head;
		if (load) begin
			result.status         <= job_q.status;
			result.command        <= job_q.command;
			result.payload_length <= job_q.length;
			result.has_byte       <= has;
			result.data_byte      <= has ? rd_data_q : 8'h00;
			result.byte_index     <= has ? idx_q : 6'd0;
			result.last           <= lst;
		end
	end

	assign result.valid = oval_q;

	// payload must not change under a drain in progress
	`CRC8FPR_ASSERT_NOW(a_wr_idle, wr.en, st_q == crc8fpr_pkg::B_IDLE, "store written while draining")
	`CRC8FPR_ASSERT_NEXT(a_push_hold, st_q == crc8fpr_pkg::B_PUSH && !out_free, st_q == crc8fpr_pkg::B_PUSH, "push left while blocked")
	`CRC8FPR_ASSERT_NOW(a_idx_range, result.valid && result.has_byte, result.byte_index < result.payload_length, "index past length")

endmodule

`default_nettype wire
